@@ design/mhpq_pkg.sv @@
// Shared constants, codes and types for the max-heap priority queue.
`default_nettype none

package mhpq_pkg;

    // Heap geometry
    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 1;

    // Word widths
    localparam int KEY_W    = 32;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 8;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Verdict of the shared compare unit
    typedef struct packed {
        logic take_a;   // candidate a beats the base key
        logic take_b;   // candidate b beats the better of base and a
    } pick_t;

endpackage

`default_nettype wire

@@ design/mhpq_store.sv @@
// Heap key storage: one write port, two registered read ports.
`default_nettype none

module mhpq_store (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [mhpq_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [mhpq_pkg::KEY_W-1:0]   wr_data,
    input  logic [mhpq_pkg::ADDR_W-1:0]  rd_addr_a,
    input  logic [mhpq_pkg::ADDR_W-1:0]  rd_addr_b,
    output logic [mhpq_pkg::KEY_W-1:0]   rd_data_a,
    output logic [mhpq_pkg::KEY_W-1:0]   rd_data_b
);
    import mhpq_pkg::*;

    logic [KEY_W-1:0] heap_mem [CAPACITY];
    logic [KEY_W-1:0] rd_a_reg;
    logic [KEY_W-1:0] rd_b_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
    end

    // Read ports, data registered
    always_ff @(posedge clk)
    begin
        rd_a_reg <= heap_mem[rd_addr_a];
        rd_b_reg <= heap_mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

@@ design/mhpq_pick.sv @@
// Shared signed compare unit: picks the strictly larger of a base key and two candidates.
`default_nettype none

module mhpq_pick (
    input  logic [mhpq_pkg::KEY_W-1:0] base_key,
    input  logic [mhpq_pkg::KEY_W-1:0] cand_a,
    input  logic                       cand_a_ok,
    input  logic [mhpq_pkg::KEY_W-1:0] cand_b,
    input  logic                       cand_b_ok,
    output mhpq_pkg::pick_t            verdict
);
    import mhpq_pkg::*;

    logic [KEY_W-1:0] best_a;

    // Ties never win: only a strictly larger key takes over
    always_comb
    begin
        verdict.take_a = cand_a_ok && ($signed(base_key) < $signed(cand_a));
        best_a         = verdict.take_a ? cand_a : base_key;
        verdict.take_b = cand_b_ok && ($signed(best_a) < $signed(cand_b));
    end

endmodule

`default_nettype wire

@@ design/max_heap_priority_queue.sv @@
// Top level of the max-heap priority queue: request sequencer, store and compare unit.
`default_nettype none

// Binary max-heap of up to CAPACITY signed 32-bit keys. Each input word is a
// request (insert a key or remove the largest key) and yields exactly one
// output word with a status, the removed key (zero unless a removal was done)
// and the low 8 bits of the entry count afterwards. One request is worked at a
// time and in_stall stays high until its word has gone to the output register.
// Each heap level of a sift has a read state, which reads the store, and a
// compare state, which compares in the single shared compare unit and writes
// back. An insert does at most 7 compares and a removal at most 6 with 128
// entries. Full and empty rejections skip the store and go straight to the
// output hand-over, which waits while a stalled output word is still held.
// The store needs no clearing after reset; only entries below the count are
// used.
module max_heap_priority_queue (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 req_type,
    input  logic signed [mhpq_pkg::KEY_W-1:0]    key_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mhpq_pkg::STAT_W-1:0]          status,
    output logic signed [mhpq_pkg::KEY_W-1:0]    removed_key,
    output logic [mhpq_pkg::COUNT_W-1:0]         count_after
);
    import mhpq_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP      = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_RM_LOAD = 3'd3;
    localparam logic [2:0] S_DN      = 3'd4;
    localparam logic [2:0] S_DN_CMP  = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]         state_reg,   state_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic [ADDR_W-1:0]  pos_reg,     pos_next;
    logic [KEY_W-1:0]   cur_key_reg, cur_key_next;
    logic [STAT_W-1:0]  res_stat_reg, res_stat_next;
    logic [KEY_W-1:0]   res_key_reg, res_key_next;

    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  out_stat_reg,  out_stat_next;
    logic [KEY_W-1:0]   out_key_reg,   out_key_next;
    logic [COUNT_W-1:0] out_cnt_reg,   out_cnt_next;

    // Store ports
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [KEY_W-1:0]   wr_data;
    logic [ADDR_W-1:0]  rd_addr_a;
    logic [ADDR_W-1:0]  rd_addr_b;
    logic [KEY_W-1:0]   rd_data_a;
    logic [KEY_W-1:0]   rd_data_b;

    // Compare unit ports
    logic [KEY_W-1:0]   cmp_base;
    logic [KEY_W-1:0]   cmp_a;
    logic               cmp_a_ok;
    logic [KEY_W-1:0]   cmp_b;
    logic               cmp_b_ok;
    pick_t              verdict;

    // Tree arithmetic
    logic               accept;
    logic [ADDR_W-1:0]  parent_pos;
    logic [IDX_W-1:0]   left_idx;
    logic [IDX_W-1:0]   right_idx;
    logic [IDX_W-1:0]   count_ext;
    logic [ADDR_W-1:0]  last_pos;

    assign accept     = in_valid && !in_stall;
    assign parent_pos = (pos_reg - ADDR_W'(1)) >> 1;
    assign left_idx   = {pos_reg, 1'b1};
    assign right_idx  = {pos_reg, 1'b1} + IDX_W'(1);
    assign count_ext  = IDX_W'(count_reg);
    assign last_pos   = ADDR_W'(count_reg - CNT_W'(1));

    mhpq_store u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    mhpq_pick u_pick (
        .base_key  (cmp_base),
        .cand_a    (cmp_a),
        .cand_a_ok (cmp_a_ok),
        .cand_b    (cmp_b),
        .cand_b_ok (cmp_b_ok),
        .verdict   (verdict)
    );

    // Compare operands: sift up checks parent < moving key, sift down checks children
    always_comb
    begin
        if (state_reg == S_UP_CMP)
        begin
            cmp_base = rd_data_a;
            cmp_a    = cur_key_reg;
            cmp_a_ok = 1'b1;
            cmp_b    = rd_data_b;
            cmp_b_ok = 1'b0;
        end
        else
        begin
            cmp_base = cur_key_reg;
            cmp_a    = rd_data_a;
            cmp_a_ok = 1'b1;
            cmp_b    = rd_data_b;
            cmp_b_ok = right_idx < count_ext;
        end
    end

    // Read addresses per state
    always_comb
    begin
        unique case (state_reg)
            S_UP:
            begin
                rd_addr_a = parent_pos;
                rd_addr_b = parent_pos;
            end
            S_DN:
            begin
                rd_addr_a = left_idx[ADDR_W-1:0];
                rd_addr_b = right_idx[ADDR_W-1:0];
            end
            default:
            begin
                rd_addr_a = '0;
                rd_addr_b = last_pos;
            end
        endcase
    end

    // Request sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        cur_key_next  = cur_key_reg;
        res_stat_next = res_stat_reg;
        res_key_next  = res_key_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_stat_next = out_stat_reg;
        out_key_next  = out_key_reg;
        out_cnt_next  = out_cnt_reg;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = cur_key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_stat_next = ST_DONE;
                    res_key_next  = '0;
                    if (req_type == REQ_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_stat_next = ST_FULL;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            cur_key_next = key_value;
                            pos_next     = ADDR_W'(count_reg);
                            count_next   = count_reg + CNT_W'(1);
                            state_next   = S_UP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_stat_next = ST_EMPTY;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RM_LOAD;
                        end
                    end
                end
            end
            S_UP:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (verdict.take_a)
                begin
                    // parent moves down, key keeps climbing
                    wr_data    = rd_data_a;
                    pos_next   = parent_pos;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RM_LOAD:
            begin
                // root and last entry arrive together
                res_key_next = rd_data_a;
                cur_key_next = rd_data_b;
                count_next   = count_reg - CNT_W'(1);
                pos_next     = '0;
                state_next   = S_DN;
            end
            S_DN:
            begin
                if (left_idx >= count_ext)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (verdict.take_b)
                begin
                    wr_data    = rd_data_b;
                    pos_next   = right_idx[ADDR_W-1:0];
                    state_next = S_DN;
                end
                else if (verdict.take_a)
                begin
                    wr_data    = rd_data_a;
                    pos_next   = left_idx[ADDR_W-1:0];
                    state_next = S_DN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand the word to the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = res_stat_reg;
                    out_key_next   = res_key_reg;
                    out_cnt_next   = COUNT_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        cur_key_reg  <= cur_key_next;
        res_stat_reg <= res_stat_next;
        res_key_reg  <= res_key_next;
        out_stat_reg <= out_stat_next;
        out_key_reg  <= out_key_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_stat_reg;
    assign removed_key = out_key_reg;
    assign count_after = out_cnt_reg;

endmodule

`default_nettype wire
